// ----- hw/rtl/bis_pkg.sv -----
// Shared constants and codes for the bicubic image scaler.
package bis_pkg;

  localparam int NUM_W      = 38;  // dividend of the position divide
  localparam int DVS_W      = 14;  // divisor of the position divide
  localparam int CNT_W      = 6;   // divider step counter
  localparam int T_W        = 16;  // signed tap fraction
  localparam int BASE_W     = 22;  // rounded source position
  localparam int INTER_W    = 24;  // vertical intermediate
  localparam int INTER_FRAC = 14;
  localparam int IDX_W      = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PREMULT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SINGLE     = 3'd5;

  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_REQUEST = 1'b1;

endpackage

// ----- hw/rtl/bis_div.sv -----
// Restoring divider, one quotient bit per cycle.
module bis_div
  import bis_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quotient_o
);

  logic [NUM_W-1:0] num_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVS_W-1:0] dvs_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_sub;
  logic             qbit;

  always_comb begin
    rem_sh  = {rem_q, num_q[NUM_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    qbit    = (rem_sh >= {1'b0, dvs_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= qbit ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      num_q <= {num_q[NUM_W-2:0], qbit};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = num_q;

endmodule

// ----- hw/rtl/bis_mul.sv -----
// Shared signed multiplier with registered product.
module bis_mul #(
  parameter int A_W = 19,
  parameter int B_W = 38
) (
  input  logic                   clk_i,
  input  logic signed [A_W-1:0]  a_i,
  input  logic signed [B_W-1:0]  b_i,
  output logic signed [A_W+B_W-1:0] p_o
);

  always_ff @(posedge clk_i) begin
    p_o <= a_i * b_i;
  end

endmodule

// ----- hw/rtl/bis_store.sv -----
// Source pixel memory, one write and one registered read port.
module bis_store #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- hw/rtl/bicubic_image_scaler.sv -----
// Bicubic image scaler top level: sequencer, weights and filter datapath.
//
// Use: write the six size and mode registers on the cfg channel while idle,
// then load the source image with func=0 items (one pixel each, no result),
// then send func=1 items, each asking for one destination pixel.
// Input and output channels use valid/ready; cfg_ready_o is always high.
// A load item is written to the store from the idle state. A request makes
// two position divides at one quotient bit per cycle, eight kernel weights
// at two multiplier passes each, then sixteen store reads plus four
// horizontal products per column on the shared multiplier. in_ready_o is
// low while a request is at work.
// The result sits in an output register; a stalled receiver holds it there,
// and the next request stops at its last step until that register frees.
// Reset clears the registers to their defaults and the control state; the
// pixel store is not cleared and must be loaded before requests read it.
module bicubic_image_scaler
  import bis_pkg::*;
#(
  parameter int MAX_WIDTH        = 256,
  parameter int MAX_HEIGHT       = 256,
  parameter int WEIGHT_FRAC_BITS = 14
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  func_i,
  input  logic [11:0]           pos_x_i,
  input  logic [11:0]           pos_y_i,
  input  logic [7:0]            in_red_i,
  input  logic [7:0]            in_green_i,
  input  logic [7:0]            in_blue_i,
  input  logic [7:0]            in_alpha_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            out_red_o,
  output logic [7:0]            out_green_o,
  output logic [7:0]            out_blue_o,
  output logic [7:0]            out_alpha_o
);

  localparam int W      = WEIGHT_FRAC_BITS;
  localparam int WT_W   = W + 2;
  localparam int MA_W   = (WT_W > 19) ? WT_W : 19;
  localparam int MB_W   = 38;
  localparam int P_W    = MA_W + MB_W;
  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int RW     = $clog2(MAX_HEIGHT);
  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW     = $clog2(DEPTH);
  localparam int VACC_W = WT_W + 11;
  localparam int VR_S   = (W >= INTER_FRAC) ? W - INTER_FRAC : 0;
  localparam int VL_S   = (W >= INTER_FRAC) ? 0 : INTER_FRAC - W;
  localparam int VX_W   = VACC_W + 8;
  localparam int HACC_W = WT_W + INTER_W + 2;
  localparam int WS     = 49 - W;
  localparam int HS     = W + INTER_FRAC;

  localparam logic [P_W:0]    WHALF = ((P_W+1)'(1) << WS) >> 1;
  localparam logic [VACC_W:0] VHALF = ((VACC_W+1)'(1) << VR_S) >> 1;
  localparam logic [HACC_W:0] HHALF = ((HACC_W+1)'(1) << HS) >> 1;
  localparam logic signed [P_W:0] K49 = (P_W+1)'(1) << 49;
  localparam logic signed [P_W:0] K50 = (P_W+1)'(1) << 50;
  localparam logic signed [MB_W-1:0] K35 = MB_W'(1) << 35;
  localparam logic signed [VX_W-1:0] IMAX = VX_W'(8388607);
  localparam logic signed [VX_W-1:0] IMIN = VX_W'(-8388608);
  localparam logic signed [18:0] X_FAR  = 19'sd98304;
  localparam logic signed [18:0] X_NEAR = 19'sd32768;
  localparam logic signed [19:0] K5     = 20'sd327680;
  localparam logic [12:0] MAXW_L = 13'(MAX_WIDTH);
  localparam logic [12:0] MAXH_L = 13'(MAX_HEIGHT);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_NUM  = 4'd1;
  localparam logic [3:0] S_NUMW = 4'd2;
  localparam logic [3:0] S_DIV  = 4'd3;
  localparam logic [3:0] S_W1   = 4'd4;
  localparam logic [3:0] S_W2   = 4'd5;
  localparam logic [3:0] S_W3   = 4'd6;
  localparam logic [3:0] S_RD   = 4'd7;
  localparam logic [3:0] S_VM   = 4'd8;
  localparam logic [3:0] S_VR   = 4'd9;
  localparam logic [3:0] S_HM   = 4'd10;
  localparam logic [3:0] S_HA   = 4'd11;
  localparam logic [3:0] S_FIN  = 4'd12;

  function automatic logic signed [WT_W-1:0] wround(input logic signed [P_W:0] p);
    logic [P_W:0] mag;
    logic [P_W:0] r;
    mag = p[P_W] ? -p : p;
    r   = (mag + WHALF) >> WS;
    return p[P_W] ? WT_W'(-r) : WT_W'(r);
  endfunction

  function automatic logic signed [INTER_W-1:0] vclamp(input logic signed [VACC_W-1:0] v);
    logic signed [VACC_W:0] ve;
    logic [VACC_W:0]        mag;
    logic [VACC_W:0]        r;
    logic signed [VX_W-1:0] s;
    ve  = {v[VACC_W-1], v};
    mag = ve[VACC_W] ? -ve : ve;
    r   = (mag + VHALF) >> VR_S;
    s   = ve[VACC_W] ? -$signed(VX_W'(r)) : $signed(VX_W'(r));
    s   = s <<< VL_S;
    if (s > IMAX) begin
      s = IMAX;
    end else if (s < IMIN) begin
      s = IMIN;
    end
    return s[INTER_W-1:0];
  endfunction

  function automatic logic signed [HACC_W:0] hround(input logic signed [HACC_W-1:0] h);
    logic signed [HACC_W:0] he;
    logic [HACC_W:0]        mag;
    logic [HACC_W:0]        r;
    he  = {h[HACC_W-1], h};
    mag = he[HACC_W] ? -he : he;
    r   = (mag + HHALF) >> HS;
    return he[HACC_W] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic [7:0] clamp8(input logic signed [HACC_W:0] v,
                                        input logic [7:0] lim);
    logic [7:0] res;
    if (v < 0) begin
      res = 8'd0;
    end else if (v > $signed({{(HACC_W-7){1'b0}}, lim})) begin
      res = lim;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

  function automatic logic [IDX_W-1:0] tap(input logic [BASE_W-1:0] base,
                                           input logic [1:0] k,
                                           input logic [8:0] n);
    logic signed [BASE_W+2:0] v;
    logic signed [BASE_W+2:0] hi;
    logic [IDX_W-1:0]         res;
    v  = $signed({3'b000, base}) + $signed({{(BASE_W+1){1'b0}}, k}) - (BASE_W+3)'(2);
    hi = $signed({{(BASE_W-6){1'b0}}, n}) - (BASE_W+3)'(1);
    if (v < 0) begin
      res = '0;
    end else if (v > hi) begin
      res = hi[IDX_W-1:0];
    end else begin
      res = v[IDX_W-1:0];
    end
    return res;
  endfunction

  function automatic logic [8:0] src_eff(input logic [8:0] v, input logic [12:0] maxv);
    logic [8:0] res;
    if (v == '0) begin
      res = 9'd1;
    end else if ({4'b0000, v} > maxv) begin
      res = maxv[8:0];
    end else begin
      res = v;
    end
    return res;
  endfunction

  // configuration registers
  logic [8:0]  src_w_q, src_h_q;
  logic [12:0] dst_w_q, dst_h_q;
  logic        premult_q, single_q;

  logic [3:0]  state_q, state_d;
  logic        axis_q;
  logic [2:0]  k_q;
  logic [1:0]  i_q, j_q, c_q;
  logic [11:0] dx_q, dy_q;
  logic [BASE_W-1:0] bx_q, by_q;
  logic signed [T_W-1:0] tx_q, ty_q;
  logic signed [WT_W-1:0] wx_q [4];
  logic signed [WT_W-1:0] wy_q [4];
  logic signed [VACC_W-1:0] vacc_q [4];
  logic signed [INTER_W-1:0] vint_q [4];
  logic signed [HACC_W-1:0] hacc_q [4];
  logic        out_valid_q;
  logic [7:0]  out_q [4];

  logic [8:0]  swe, she;
  logic [12:0] dwe, dhe;
  logic        in_acc;
  logic        store_we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0] rdata;
  logic        div_start, div_done;
  logic [NUM_W-1:0] quot;
  logic [DVS_W-1:0] divisor;
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [P_W-1:0]  mul_p;
  logic signed [P_W:0]    pext;
  logic signed [T_W-1:0]  tsel;
  logic signed [18:0]     xw;
  logic signed [19:0]     xe;
  logic                   outer;
  logic signed [WT_W-1:0] wnew;
  logic [IDX_W-1:0]       col_t, row_t;
  logic [11:0]            dsel;
  logic [8:0]             ssel;
  logic signed [HACC_W:0] hr [4];
  logic [7:0]             alpha8, lim;
  logic                   out_load;

  assign swe = src_eff(src_w_q, MAXW_L);
  assign she = src_eff(src_h_q, MAXH_L);
  assign dwe = (dst_w_q == '0) ? 13'd1 : dst_w_q;
  assign dhe = (dst_h_q == '0) ? 13'd1 : dst_h_q;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;

  assign store_we = in_acc && (func_i == FUNC_LOAD) &&
                    ({1'b0, pos_x_i} < MAXW_L) && ({1'b0, pos_y_i} < MAXH_L);
  assign waddr = AW'(pos_y_i[RW-1:0]) * AW'(MAX_WIDTH) + AW'(pos_x_i[CW-1:0]);

  assign col_t = tap(bx_q, i_q, swe);
  assign row_t = tap(by_q, j_q, she);
  assign raddr = AW'(row_t[RW-1:0]) * AW'(MAX_WIDTH) + AW'(col_t[CW-1:0]);

  bis_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (waddr),
    .wdata_i ({in_alpha_i, in_blue_i, in_green_i, in_red_i}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // divide setup
  assign dsel      = axis_q ? dy_q : dx_q;
  assign ssel      = axis_q ? she : swe;
  assign divisor   = axis_q ? {dhe, 1'b0} : {dwe, 1'b0};
  assign div_start = (state_q == S_NUMW);

  bis_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({mul_p[NUM_W-17:0], 16'b0}),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  // weight operand
  assign tsel  = k_q[2] ? ty_q : tx_q;
  assign outer = (k_q[1:0] == 2'd0) || (k_q[1:0] == 2'd3);
  always_comb begin
    case (k_q[1:0])
      2'd0:    xw = X_FAR + 19'(tsel);
      2'd1:    xw = X_NEAR + 19'(tsel);
      2'd2:    xw = X_NEAR - 19'(tsel);
      default: xw = X_FAR - 19'(tsel);
    endcase
    xe = {xw[18], xw};
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_NUM: begin
        mul_a = MA_W'({dsel, 1'b1});
        mul_b = MB_W'(ssel);
      end
      S_W1: begin
        mul_a = MA_W'(xw);
        mul_b = outer ? MB_W'(xe - K5) : MB_W'((xe <<< 1) + xe - K5);
      end
      S_W2: begin
        mul_a = MA_W'(xw);
        mul_b = outer ? mul_p[MB_W-1:0] + K35 : mul_p[MB_W-1:0];
      end
      S_HM: begin
        mul_a = MA_W'(wx_q[i_q]);
        mul_b = MB_W'(vint_q[c_q]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  bis_mul #(.A_W(MA_W), .B_W(MB_W)) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign pext = {mul_p[P_W-1], mul_p};
  assign wnew = outer ? wround(K50 - pext) : wround(pext + K49);

  // result formatting
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      hr[c] = hround(hacc_q[c]);
    end
    alpha8 = clamp8(hr[3], 8'd255);
    lim    = premult_q ? alpha8 : 8'd255;
  end
  assign out_load = (state_q == S_FIN) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_acc && (func_i == FUNC_REQUEST)) state_d = S_NUM;
      S_NUM:  state_d = S_NUMW;
      S_NUMW: state_d = S_DIV;
      S_DIV:  if (div_done) state_d = axis_q ? S_W1 : S_NUM;
      S_W1:   state_d = S_W2;
      S_W2:   state_d = S_W3;
      S_W3:   state_d = (k_q == 3'd7) ? S_RD : S_W1;
      S_RD:   state_d = S_VM;
      S_VM:   state_d = (j_q == 2'd3) ? S_VR : S_RD;
      S_VR:   state_d = S_HM;
      S_HM:   state_d = S_HA;
      S_HA: begin
        if (c_q == 2'd3) begin
          state_d = (i_q == 2'd3) ? S_FIN : S_RD;
        end else begin
          state_d = S_HM;
        end
      end
      S_FIN:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      axis_q      <= 1'b0;
      k_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      c_q         <= '0;
      out_valid_q <= 1'b0;
      src_w_q     <= 9'd1;
      src_h_q     <= 9'd1;
      dst_w_q     <= 13'd1;
      dst_h_q     <= 13'd1;
      premult_q   <= 1'b0;
      single_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_SRC_WIDTH:  src_w_q   <= cfg_data_i[8:0];
          CFG_SRC_HEIGHT: src_h_q   <= cfg_data_i[8:0];
          CFG_DST_WIDTH:  dst_w_q   <= cfg_data_i;
          CFG_DST_HEIGHT: dst_h_q   <= cfg_data_i;
          CFG_PREMULT:    premult_q <= cfg_data_i[0];
          CFG_SINGLE:     single_q  <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          axis_q <= 1'b0;
          k_q    <= '0;
          i_q    <= '0;
          j_q    <= '0;
          c_q    <= '0;
        end
        S_DIV:  if (div_done) axis_q <= 1'b1;
        S_W3:   k_q <= k_q + 1'b1;
        S_VM:   j_q <= j_q + 1'b1;
        S_VR:   c_q <= '0;
        S_HA: begin
          c_q <= c_q + 1'b1;
          if (c_q == 2'd3) i_q <= i_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        dx_q <= pos_x_i;
        dy_q <= pos_y_i;
      end
      S_DIV: begin
        if (div_done) begin
          if (axis_q) begin
            by_q <= quot[NUM_W-1:16] + BASE_W'(quot[15]);
            ty_q <= $signed(quot[15:0]);
          end else begin
            bx_q <= quot[NUM_W-1:16] + BASE_W'(quot[15]);
            tx_q <= $signed(quot[15:0]);
          end
        end
      end
      S_W3: begin
        if (k_q[2]) begin
          wy_q[k_q[1:0]] <= wnew;
        end else begin
          wx_q[k_q[1:0]] <= wnew;
        end
      end
      S_VM: begin
        for (int c = 0; c < 4; c++) begin
          if (j_q == 2'd0) begin
            vacc_q[c] <= VACC_W'(wy_q[j_q] * $signed({1'b0, rdata[8*c +: 8]}));
          end else begin
            vacc_q[c] <= vacc_q[c] +
                         VACC_W'(wy_q[j_q] * $signed({1'b0, rdata[8*c +: 8]}));
          end
        end
      end
      S_VR: begin
        for (int c = 0; c < 4; c++) begin
          vint_q[c] <= vclamp(vacc_q[c]);
        end
      end
      S_HA: begin
        if (i_q == 2'd0) begin
          hacc_q[c_q] <= mul_p[HACC_W-1:0];
        end else begin
          hacc_q[c_q] <= hacc_q[c_q] + mul_p[HACC_W-1:0];
        end
      end
      S_FIN: begin
        if (out_load) begin
          out_q[3] <= alpha8;
          for (int c = 0; c < 3; c++) begin
            out_q[c] <= single_q ? 8'd0 : clamp8(hr[c], lim);
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_red_o   = out_q[0];
  assign out_green_o = out_q[1];
  assign out_blue_o  = out_q[2];
  assign out_alpha_o = out_q[3];

endmodule

// ----- bench/tb.sv -----
// Self-checking testbench for the bicubic image scaler: loads, requests, config phases.
`timescale 1ns / 1ps

module tb
  import bis_pkg::*;
();

  class scaler_scoreboard;
    bit [31:0] pixels [65536];
    int unsigned src_w, src_h, dst_w, dst_h;
    bit premult, single;
    bit [31:0] expected_px [$];
    int errors;

    function new();
      src_w = 1; src_h = 1; dst_w = 1; dst_h = 1;
      premult = 0; single = 0; errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_SRC_WIDTH:  src_w = data[8:0];
        CFG_SRC_HEIGHT: src_h = data[8:0];
        CFG_DST_WIDTH:  dst_w = data;
        CFG_DST_HEIGHT: dst_h = data;
        CFG_PREMULT:    premult = data[0];
        CFG_SINGLE:     single = data[0];
        default: ;
      endcase
    endfunction

    function longint rnd_shift(longint v, int s);
      longint mag;
      if (s == 0) return v;
      mag = (v < 0) ? -v : v;
      mag = (mag + (longint'(1) << (s - 1))) >>> s;
      return (v < 0) ? -mag : mag;
    endfunction

    function longint clampl(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function int unsigned eff(int unsigned v, int unsigned maxv);
      if (v == 0) return 1;
      return v > maxv ? maxv : v;
    endfunction

    function void locate(int unsigned d, int unsigned src, int unsigned dst,
                         output longint base, output longint t);
      longint unsigned num, pos, r;
      num = ((longint'(2) * d + 1) * src) << 16;
      pos = num / (longint'(2) * dst);
      r = (pos + 32768) >> 16;
      base = r;
      t = longint'(pos) - longint'(r << 16);
    endfunction

    function void kernel(longint t, output longint w [4]);
      longint xs [4];
      longint x, x2, x3, p;
      xs[0] = 98304 + t; xs[1] = 32768 + t; xs[2] = 32768 - t; xs[3] = 98304 - t;
      for (int i = 0; i < 4; i++) begin
        x = xs[i]; x2 = x * x; x3 = x2 * x;
        if (i == 0 || i == 3) begin
          p = x3 - 5 * x2 * 65536 + 8 * x * (longint'(1) << 32) - 4 * (longint'(1) << 48);
          w[i] = rnd_shift(-p, 35);
        end else begin
          p = 3 * x3 - 5 * x2 * 65536 + 2 * (longint'(1) << 48);
          w[i] = rnd_shift(p, 35);
        end
      end
    endfunction

    function longint filter_channel(int unsigned rows [4], int unsigned cols [4],
                                    longint wy [4], longint wx [4], int ch);
      longint h, v;
      bit [31:0] px;
      h = 0;
      for (int i = 0; i < 4; i++) begin
        v = 0;
        for (int j = 0; j < 4; j++) begin
          px = pixels[(rows[j] * 256 + cols[i]) % 65536];
          v += wy[j] * longint'((px >> (8 * ch)) & 8'hFF);
        end
        v = clampl(v, -8388608, 8388607);
        h += wx[i] * v;
      end
      return rnd_shift(h, 28);
    endfunction

    function void note_item(logic func, logic [11:0] px, logic [11:0] py,
                            logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
      int unsigned sw, sh, dw, dh;
      int unsigned rows [4], cols [4];
      longint bx, tx, by, ty, ch [4];
      longint wx [4], wy [4];
      if (func == FUNC_LOAD) begin
        if (px < 256 && py < 256) pixels[py * 256 + px] = {a, b, g, r};
        return;
      end
      sw = eff(src_w, 256); sh = eff(src_h, 256);
      dw = eff(dst_w, 8191); dh = eff(dst_h, 8191);
      locate(px, sw, dw, bx, tx);
      locate(py, sh, dh, by, ty);
      kernel(tx, wx);
      kernel(ty, wy);
      for (int i = 0; i < 4; i++) begin
        cols[i] = clampl(bx + i - 2, 0, sw - 1);
        rows[i] = clampl(by + i - 2, 0, sh - 1);
      end
      for (int k = 0; k < 4; k++) ch[k] = 0;
      if (single) begin
        ch[3] = clampl(filter_channel(rows, cols, wy, wx, 3), 0, 255);
      end else begin
        for (int k = 0; k < 4; k++) ch[k] = filter_channel(rows, cols, wy, wx, k);
        ch[3] = clampl(ch[3], 0, 255);
        for (int k = 0; k < 3; k++) ch[k] = clampl(ch[k], 0, premult ? ch[3] : 255);
      end
      expected_px.push_back({ch[3][7:0], ch[2][7:0], ch[1][7:0], ch[0][7:0]});
    endfunction

    function void check_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
      bit [31:0] e;
      if (expected_px.size() == 0) begin
        $error("unexpected pixel out r=%0d g=%0d b=%0d a=%0d", r, g, b, a);
        errors++;
        return;
      end
      e = expected_px.pop_front();
      if (r !== e[7:0]) begin
        $error("out_red expected %0d actual %0d", e[7:0], r); errors++;
      end
      if (g !== e[15:8]) begin
        $error("out_green expected %0d actual %0d", e[15:8], g); errors++;
      end
      if (b !== e[23:16]) begin
        $error("out_blue expected %0d actual %0d", e[23:16], b); errors++;
      end
      if (a !== e[31:24]) begin
        $error("out_alpha expected %0d actual %0d", e[31:24], a); errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic cfg_valid_i, cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic in_valid_i, in_ready_o, func_i;
  logic [11:0] pos_x_i, pos_y_i;
  logic [7:0] in_red_i, in_green_i, in_blue_i, in_alpha_i;
  logic out_valid_o, out_ready_i;
  logic [7:0] out_red_o, out_green_o, out_blue_o, out_alpha_o;

  scaler_scoreboard sb = new();
  int items_sent;
  bit hold_go;

  bicubic_image_scaler DUT (.*);

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("tb failed");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  task automatic send_item(logic f, logic [11:0] px, logic [11:0] py, logic [31:0] rgba);
    int gap;
    in_valid_i <= 1; func_i <= f; pos_x_i <= px; pos_y_i <= py;
    {in_alpha_i, in_blue_i, in_green_i, in_red_i} <= rgba;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_item(f, px, py, rgba[7:0], rgba[15:8], rgba[23:16], rgba[31:24]);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (sb.expected_px.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned data);
    cfg_valid_i <= 1; cfg_index_i <= idx; cfg_data_i <= CFG_DATA_W'(data);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, CFG_DATA_W'(data));
    cfg_valid_i <= 0;
    @(posedge clk_i);
  endtask

  task automatic setup(int unsigned sw, int unsigned sh, int unsigned dw, int unsigned dh,
                       bit pm, bit sc);
    drain();
    write_reg(CFG_SRC_WIDTH, sw);
    write_reg(CFG_SRC_HEIGHT, sh);
    write_reg(CFG_DST_WIDTH, dw);
    write_reg(CFG_DST_HEIGHT, dh);
    write_reg(CFG_PREMULT, pm);
    write_reg(CFG_SINGLE, sc);
  endtask

  task automatic load_image(bit harsh);
    int unsigned sw, sh;
    logic [31:0] px;
    sw = sb.eff(sb.src_w, 256);
    sh = sb.eff(sb.src_h, 256);
    for (int y = 0; y < sh; y++)
      for (int x = 0; x < sw; x++) begin
        if ($urandom_range(0, 15) == 0)
          send_item(FUNC_LOAD, 12'($urandom_range(256, 4095)), 12'($urandom()), $urandom());
        if (harsh) px = {4{(x + y) % 2 ? 8'hFF : 8'h00}} ^ {$urandom_range(0, 1) ? 8'hFF : 8'h00, 24'h0};
        else px = $urandom();
        send_item(FUNC_LOAD, 12'(x), 12'(y), px);
      end
  endtask

  task automatic run_requests(int n);
    int unsigned dw, dh;
    logic [11:0] px, py;
    dw = sb.eff(sb.dst_w, 4096);
    dh = sb.eff(sb.dst_h, 4096);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) != 0) begin
        px = 12'($urandom_range(0, dw - 1)); py = 12'($urandom_range(0, dh - 1));
      end else begin
        px = 12'($urandom()); py = 12'($urandom());
      end
      send_item(FUNC_REQUEST, px, py, $urandom());
    end
  endtask

  initial begin
    rst_ni = 0;
    cfg_valid_i = 0; cfg_index_i = '0; cfg_data_i = '0;
    in_valid_i = 0; func_i = 0; pos_x_i = '0; pos_y_i = '0;
    in_red_i = '0; in_green_i = '0; in_blue_i = '0; in_alpha_i = '0;
    items_sent = 0; hold_go = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    setup(4, 4, 8, 8, 0, 0);
    load_image(1);
    send_item(FUNC_REQUEST, 0, 0, 0);
    send_item(FUNC_REQUEST, 7, 7, 0);
    send_item(FUNC_REQUEST, 12'hFFF, 12'hFFF, 0);
    send_item(FUNC_REQUEST, 0, 12'hFFF, 0);
    send_item(FUNC_REQUEST, 3, 4, 0);

    setup(0, 0, 0, 0, 1, 0);
    load_image(0);
    run_requests(3);
    setup(256, 1, 8191, 4096, 0, 1);
    load_image(0);
    run_requests(8);
    setup(1, 511, 1, 4096, 1, 0);
    load_image(1);
    hold_go <= 1;
    run_requests(20);
    setup(5, 6, 3, 2, 1, 1);
    load_image(1);
    run_requests(10);

    while (items_sent < 1950) begin
      setup($urandom_range(1, 10), $urandom_range(1, 10),
            $urandom_range(0, 3) == 0 ? $urandom_range(1, 4096) : $urandom_range(1, 24),
            $urandom_range(0, 3) == 0 ? $urandom_range(1, 4096) : $urandom_range(1, 24),
            $urandom_range(0, 1), $urandom_range(0, 3) == 0);
      load_image($urandom_range(0, 2) == 0);
      run_requests($urandom_range(20, 50));
    end

    in_valid_i <= 0;
    while (sb.expected_px.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_px.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    bit held;
    held = 0;
    out_ready_i = 0;
    forever begin
      @(posedge clk_i);
      if (hold_go && !held) begin
        out_ready_i <= 0;
        repeat (3000) @(posedge clk_i);
        held = 1;
      end
      out_ready_i <= 1;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      if (pick_gap() > 0) begin
        out_ready_i <= 0;
        repeat (pick_gap() + 1) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_pixel(out_red_o, out_green_o, out_blue_o, out_alpha_o);
  end

endmodule
